// ===== src/stream_subsequence_replace_unit_macros.svh =====
// assertion macros used by the top-level rtl file of the subsequence replace unit
`ifndef STREAM_SUBSEQUENCE_REPLACE_UNIT_MACROS_SVH
`define STREAM_SUBSEQUENCE_REPLACE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// property that holds at every edge outside reset
`define SSR_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
    else $error(msg);

// same-cycle implication outside reset
`define SSR_ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

`else

`define SSR_ASSERT(label, clk_s, rst_s, prop, msg)

`define SSR_ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg)

`endif

`endif

// ===== src/ssr_pkg.sv =====
// shared types, constants and helpers of the subsequence replace unit
`default_nettype none

package ssr_pkg;

  localparam int ELEM_BITS   = 16;
  localparam int WORD_BITS   = 64;
  localparam int MAX_PATTERN = 4;
  localparam int MAX_REPLACE = 4;
  localparam int LEN_BITS    = 3;
  localparam int CFG_IDX_W   = 2;

  typedef logic signed [ELEM_BITS-1:0] elem_t;
  typedef logic [WORD_BITS-1:0]        word_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LEN  = 2'd0,
    REG_PATTERN_WORD = 2'd1,
    REG_REPLACE_LEN  = 2'd2,
    REG_REPLACE_WORD = 2'd3
  } ssr_reg_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_RUN,
    ST_REPL,
    ST_FLUSH
  } ssr_state_t;

  // per-cell load controls
  typedef struct packed {
    logic take_in;
    logic take_next;
  } ssr_cell_ctl_t;

  // element idx of a packed word, zero past the word's top
  function automatic elem_t packed_elem(input word_t word, input int idx);
    word_t sh;
    sh = word >> (idx * ELEM_BITS);
    return elem_t'(sh[ELEM_BITS-1:0]);
  endfunction

endpackage

`default_nettype wire

// ===== src/ssr_chan_if.sv =====
// valid/ready channel interfaces for input, result and configuration
`default_nettype none

interface ssr_in_if;
  logic          valid;
  logic          ready;
  ssr_pkg::elem_t elem;
  logic          is_last;

  modport source (output valid, output elem, output is_last, input ready);
  modport sink   (input valid, input elem, input is_last, output ready);
endinterface

interface ssr_out_if;
  logic          valid;
  logic          ready;
  ssr_pkg::elem_t out_elem;
  logic          has_elem;
  logic          out_last;

  modport source (output valid, output out_elem, output has_elem, output out_last,
                  input ready);
  modport sink   (input valid, input out_elem, input has_elem, input out_last,
                  output ready);
endinterface

interface ssr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ssr_pkg::CFG_IDX_W-1:0]   index;
  ssr_pkg::word_t                  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/ssr_cell.sv =====
// one window cell: holds a pending element and compares it with its pattern element
`default_nettype none

module ssr_cell (
  input  wire                    clk,
  input  ssr_pkg::ssr_cell_ctl_t ctl,
  input  ssr_pkg::elem_t         in_data,
  input  ssr_pkg::elem_t         next_data,
  input  ssr_pkg::elem_t         pat_elem,
  output ssr_pkg::elem_t         data,
  output logic                   eq
);

  ssr_pkg::elem_t data_r;

  // load from the input or take the neighbor's element
  always_ff @(posedge clk) begin
    if (ctl.take_in) begin
      data_r <= in_data;
    end else if (ctl.take_next) begin
      data_r <= next_data;
    end
  end

  assign data = data_r;
  assign eq   = (data_r == pat_elem);

endmodule

`default_nettype wire

// ===== src/stream_subsequence_replace_unit.sv =====
// top level of the streaming subsequence find-and-replace unit
// Replaces every leftmost, non-overlapping occurrence of a pattern of 1 to
// MAX_PATTERN elements by a replacement of 0 to MAX_REPLACE elements. Pending
// elements sit in a row of MAX_PATTERN cells that shift toward the output one
// place per cycle as results go out; each cell compares its element against
// its pattern element, so a full window is matched in the cycle the newest
// element arrives. An element that gives at most one result is taken every
// cycle while the output is free. A match with a replacement of more than one
// element holds the input while the index steps, and a last element with cells
// pending holds it while the row drains. A last element with nothing to give
// yields one empty marker. The result register lets a new element enter in
// the same cycle the previous result is taken. Configuration writes take
// effect at once and must only be made while the unit is idle, which it does
// not enforce; writing the pattern length empties the window.
`default_nettype none
`include "stream_subsequence_replace_unit_macros.svh"

module stream_subsequence_replace_unit #(
  parameter int MAX_PATTERN = ssr_pkg::MAX_PATTERN,
  parameter int MAX_REPLACE = ssr_pkg::MAX_REPLACE
) (
  input wire        clk,
  input wire        rst_n,
  ssr_in_if.sink    in_chan,
  ssr_out_if.source out_chan,
  ssr_cfg_if.sink   cfg_chan
);

  localparam int CNT_W  = $clog2(MAX_PATTERN + 1);
  localparam int RLEN_W = $clog2(MAX_REPLACE + 2);

  // configuration
  logic [CNT_W-1:0]           plen_r;
  logic [RLEN_W-1:0]          rlen_r;
  ssr_pkg::word_t             pat_word_r;
  ssr_pkg::word_t             rep_word_r;
  logic [ssr_pkg::LEN_BITS-1:0] cfg_len;
  logic [CNT_W-1:0]           plen_wr;
  logic [RLEN_W-1:0]          rlen_wr;
  logic                       cfg_fire;

  // sequencer and window count
  ssr_pkg::ssr_state_t state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [RLEN_W-1:0]   rep_idx_r, rep_idx_nxt;
  logic                last_pend_r, last_pend_nxt;

  // result register
  logic           out_valid_r, out_valid_nxt;
  ssr_pkg::elem_t out_elem_r, out_elem_nxt;
  logic           has_elem_r, has_elem_nxt;
  logic           out_last_r, out_last_nxt;

  // cell row
  ssr_pkg::elem_t         cell_data [MAX_PATTERN];
  ssr_pkg::elem_t         cell_pat  [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_eq;
  ssr_pkg::ssr_cell_ctl_t cell_ctl  [MAX_PATTERN];

  logic             in_ready;
  logic             in_fire;
  logic             out_free;
  logic             full;
  logic             in_eq;
  logic             win_eq;
  logic             shift_en;
  logic             load_en;
  logic [CNT_W-1:0] load_pos;
  ssr_pkg::elem_t   head;
  ssr_pkg::elem_t   pat_top;
  ssr_pkg::elem_t   rep_first;
  ssr_pkg::elem_t   rep_cur;

  // configuration port, always ready
  assign cfg_chan.ready = 1'b1;
  assign cfg_fire       = cfg_chan.valid;
  assign cfg_len        = cfg_chan.data[ssr_pkg::LEN_BITS-1:0];

  // length clamps
  always_comb begin
    if (cfg_len == '0) begin
      plen_wr = CNT_W'(1);
    end else if (int'(cfg_len) > MAX_PATTERN) begin
      plen_wr = CNT_W'(MAX_PATTERN);
    end else begin
      plen_wr = CNT_W'(cfg_len);
    end
    if (int'(cfg_len) > MAX_REPLACE) begin
      rlen_wr = RLEN_W'(MAX_REPLACE);
    end else begin
      rlen_wr = RLEN_W'(cfg_len);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r     <= CNT_W'(1);
      rlen_r     <= '0;
      pat_word_r <= '0;
      rep_word_r <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_chan.index)
        ssr_pkg::REG_PATTERN_LEN:  plen_r     <= plen_wr;
        ssr_pkg::REG_PATTERN_WORD: pat_word_r <= cfg_chan.data;
        ssr_pkg::REG_REPLACE_LEN:  rlen_r     <= rlen_wr;
        ssr_pkg::REG_REPLACE_WORD: rep_word_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // the cell row
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    assign cell_pat[k] = ssr_pkg::packed_elem(pat_word_r, k);

    ssr_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[k]),
      .in_data   (in_chan.elem),
      .next_data ((k + 1 < MAX_PATTERN) ? cell_data[(k + 1) % MAX_PATTERN] : in_chan.elem),
      .pat_elem  (cell_pat[k]),
      .data      (cell_data[k]),
      .eq        (cell_eq[k])
    );

    assign cell_ctl[k].take_next = shift_en && ((k + 1) < int'(cnt_r));
    assign cell_ctl[k].take_in   = load_en && (int'(load_pos) == k);
  end

  // match of the pending cells and the arriving element
  always_comb begin
    win_eq = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if ((k < int'(cnt_r)) && !cell_eq[k]) begin
        win_eq = 1'b0;
      end
    end
  end

  assign pat_top   = ssr_pkg::packed_elem(pat_word_r, int'(plen_r) - 1);
  assign in_eq     = (in_chan.elem == pat_top);
  assign full      = (cnt_r == CNT_W'(plen_r - 1'b1));
  assign head      = (cnt_r == '0) ? in_chan.elem : cell_data[0];
  assign rep_first = ssr_pkg::packed_elem(rep_word_r, 0);
  assign rep_cur   = ssr_pkg::packed_elem(rep_word_r, int'(rep_idx_r));

  // handshake
  assign out_free       = !out_valid_r || out_chan.ready;
  assign in_ready       = (state_r == ssr_pkg::ST_RUN) && out_free;
  assign in_fire        = in_chan.valid && in_ready;
  assign in_chan.ready  = in_ready;

  // sequencer next state and result load
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rep_idx_nxt   = rep_idx_r;
    last_pend_nxt = last_pend_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_elem_nxt  = out_elem_r;
    has_elem_nxt  = has_elem_r;
    out_last_nxt  = out_last_r;
    shift_en      = 1'b0;
    load_en       = 1'b0;
    load_pos      = cnt_r;

    unique case (state_r)
      ssr_pkg::ST_RUN: begin
        if (in_fire) begin
          if (full && in_eq && win_eq) begin
            // match: start the replacement
            cnt_nxt = '0;
            if (rlen_r != '0) begin
              out_valid_nxt = 1'b1;
              out_elem_nxt  = rep_first;
              has_elem_nxt  = 1'b1;
              out_last_nxt  = in_chan.is_last && (rlen_r == RLEN_W'(1));
              if (rlen_r != RLEN_W'(1)) begin
                state_nxt     = ssr_pkg::ST_REPL;
                rep_idx_nxt   = RLEN_W'(1);
                last_pend_nxt = in_chan.is_last;
              end
            end else if (in_chan.is_last) begin
              out_valid_nxt = 1'b1;
              out_elem_nxt  = '0;
              has_elem_nxt  = 1'b0;
              out_last_nxt  = 1'b1;
            end
          end else if (full) begin
            // mismatch: oldest out, window slides
            out_valid_nxt = 1'b1;
            out_elem_nxt  = head;
            has_elem_nxt  = 1'b1;
            out_last_nxt  = in_chan.is_last && (cnt_r == '0);
            shift_en      = 1'b1;
            load_en       = (cnt_r != '0);
            load_pos      = CNT_W'(cnt_r - 1'b1);
            if (in_chan.is_last && (cnt_r != '0)) begin
              state_nxt = ssr_pkg::ST_FLUSH;
            end
          end else begin
            // window not yet full: append
            load_en = 1'b1;
            cnt_nxt = CNT_W'(cnt_r + 1'b1);
            if (in_chan.is_last) begin
              state_nxt = ssr_pkg::ST_FLUSH;
            end
          end
        end
      end
      ssr_pkg::ST_REPL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_elem_nxt  = rep_cur;
          has_elem_nxt  = 1'b1;
          out_last_nxt  = last_pend_r && (rep_idx_r == RLEN_W'(rlen_r - 1'b1));
          rep_idx_nxt   = RLEN_W'(rep_idx_r + 1'b1);
          if (rep_idx_r == RLEN_W'(rlen_r - 1'b1)) begin
            state_nxt = ssr_pkg::ST_RUN;
          end
        end
      end
      ssr_pkg::ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_elem_nxt  = cell_data[0];
          has_elem_nxt  = 1'b1;
          out_last_nxt  = (cnt_r == CNT_W'(1));
          shift_en      = 1'b1;
          cnt_nxt       = CNT_W'(cnt_r - 1'b1);
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = ssr_pkg::ST_RUN;
          end
        end
      end
      default: begin
        state_nxt = ssr_pkg::ST_RUN;
      end
    endcase

    // a new pattern length empties the window
    if (cfg_fire && (cfg_chan.index == ssr_pkg::REG_PATTERN_LEN)) begin
      cnt_nxt = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssr_pkg::ST_RUN;
      cnt_r       <= '0;
      rep_idx_r   <= '0;
      last_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rep_idx_r   <= rep_idx_nxt;
      last_pend_r <= last_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_elem_r <= out_elem_nxt;
    has_elem_r <= has_elem_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_elem = out_elem_r;
  assign out_chan.has_elem = has_elem_r;
  assign out_chan.out_last = out_last_r;

  // checks
  `SSR_ASSERT(a_cnt_below_len, clk, rst_n, cnt_r < plen_r, "window count reached pattern length")
  `SSR_ASSERT_IMPL(a_repl_idx, clk, rst_n, state_r == ssr_pkg::ST_REPL, (rep_idx_r != '0) && (rep_idx_r < rlen_r), "replacement index out of range")
  `SSR_ASSERT_IMPL(a_flush_nonempty, clk, rst_n, state_r == ssr_pkg::ST_FLUSH, cnt_r != '0, "flush with empty window")
  `SSR_ASSERT_IMPL(a_last_empty, clk, rst_n, out_valid_r && out_last_r, (cnt_r == '0) && (state_r == ssr_pkg::ST_RUN), "final result while elements pending")

endmodule

`default_nettype wire
